@@ rtl/core/grs_pkg.sv @@
// ----------------------------------------------------------------------------
// grs_pkg
// Shared types and constants for the group reverse stream block: payload
// structs, the descriptor handed from front to back, and the back-end states.
// ----------------------------------------------------------------------------
package grs_pkg;

    // field widths
    localparam int GRS_VAL_W     = 32;
    localparam int GRS_SIZE_W    = 7;
    localparam int GRS_DEPTH_MAX = 64;
    localparam int GRS_AW_MAX    = 6;
    localparam int GRS_OQ_DEPTH  = 4;

    // default group buffer depth
    localparam int GRS_MAX_GROUP = 64;

    // input item
    typedef struct packed {
        logic signed [GRS_VAL_W-1:0] value;
        logic                        list_last;
    } t_grs_in;

    // result item
    typedef struct packed {
        logic signed [GRS_VAL_W-1:0] out_value;
        logic                        group_end;
        logic                        list_end;
    } t_grs_out;

    // buffer write from the front
    typedef struct packed {
        logic                        en;
        logic                        bank;
        logic [GRS_AW_MAX-1:0]       addr;
        logic signed [GRS_VAL_W-1:0] data;
    } t_grs_wr;

    // closed group: bank, address of its newest entry, list end flag
    typedef struct packed {
        logic                  bank;
        logic [GRS_AW_MAX-1:0] top;
        logic                  last;
    } t_grs_desc;

    // back-end drain states
    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } t_back_state;

endpackage

@@ rtl/core/grs_front.sv @@
// ----------------------------------------------------------------------------
// grs_front
// Accepts items, writes them into the current buffer bank and closes a group
// when it fills or the list ends, handing a descriptor to the back end.
// ----------------------------------------------------------------------------
module grs_front #(
    parameter int MAX_GROUP = grs_pkg::GRS_MAX_GROUP
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  grs_pkg::t_grs_in                i_item,
    input  logic                            i_cfg_we,
    input  logic [grs_pkg::GRS_SIZE_W-1:0]  i_cfg_data,
    input  logic [1:0]                      i_release,
    output grs_pkg::t_grs_wr                o_wr,
    output logic                            o_desc_push,
    output grs_pkg::t_grs_desc              o_desc
);

    localparam logic [grs_pkg::GRS_SIZE_W-1:0] MaxK = grs_pkg::GRS_SIZE_W'(MAX_GROUP);

    logic [grs_pkg::GRS_SIZE_W-1:0] r_group_size, n_group_size;
    logic [grs_pkg::GRS_SIZE_W-1:0] r_fill, n_fill;
    logic                           r_bank, n_bank;
    logic [1:0]                     r_busy, n_busy;

    logic [grs_pkg::GRS_SIZE_W-1:0] k_eff;
    logic [grs_pkg::GRS_SIZE_W-1:0] fill_inc;
    logic                           accept;
    logic                           close;

    // effective group size, saturated to 1 .. MAX_GROUP
    always_comb begin
        if (r_group_size == '0) begin
            k_eff = grs_pkg::GRS_SIZE_W'(1);
        end else if (r_group_size > MaxK) begin
            k_eff = MaxK;
        end else begin
            k_eff = r_group_size;
        end
    end

    // accept and close decisions
    assign full     = r_busy[r_bank];
    assign accept   = push && !full;
    assign fill_inc = r_fill + grs_pkg::GRS_SIZE_W'(1);
    assign close    = accept && ((fill_inc >= k_eff) || i_item.list_last);

    // next state
    always_comb begin
        n_group_size = i_cfg_we ? i_cfg_data : r_group_size;
        n_fill       = r_fill;
        n_bank       = r_bank;
        if (accept) begin
            n_fill = close ? '0 : fill_inc;
        end
        if (close) begin
            n_bank = ~r_bank;
        end
        n_busy = (r_busy & ~i_release) | (close ? (2'b01 << r_bank) : 2'b00);
    end

    // buffer write and descriptor
    always_comb begin
        o_wr.en       = accept;
        o_wr.bank     = r_bank;
        o_wr.addr     = grs_pkg::GRS_AW_MAX'(r_fill);
        o_wr.data     = i_item.value;
        o_desc_push   = close;
        o_desc.bank   = r_bank;
        o_desc.top    = grs_pkg::GRS_AW_MAX'(r_fill);
        o_desc.last   = i_item.list_last;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= grs_pkg::GRS_SIZE_W'(1);
            r_fill       <= '0;
            r_bank       <= 1'b0;
            r_busy       <= 2'b00;
        end else begin
            r_group_size <= n_group_size;
            r_fill       <= n_fill;
            r_bank       <= n_bank;
            r_busy       <= n_busy;
        end
    end

    // fill count stays inside one bank
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < grs_pkg::GRS_SIZE_W'(MAX_GROUP))
        else $error("fill count beyond group buffer depth");

    // only a bank owed to the back end is ever released
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_release & ~r_busy) == 2'b00)
        else $error("release of a bank that was not busy");

endmodule

@@ rtl/core/grs_desc_queue.sv @@
// ----------------------------------------------------------------------------
// grs_desc_queue
// Two-entry queue of closed-group descriptors between front and back end.
// ----------------------------------------------------------------------------
module grs_desc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  grs_pkg::t_grs_desc  i_desc,
    input  logic                i_pop,
    output logic                o_empty,
    output logic                o_full,
    output grs_pkg::t_grs_desc  o_head
);

    grs_pkg::t_grs_desc r_slot [2];
    logic               r_wp, n_wp;
    logic               r_rp, n_rp;
    logic [1:0]         r_cnt, n_cnt;

    // status and head
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_head  = r_slot[r_rp];

    // pointer update
    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = i_pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // descriptor storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_desc;
        end
    end

    // two banks never owe more than two descriptors
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("descriptor queue overflow");

endmodule

@@ rtl/core/grs_back.sv @@
// ----------------------------------------------------------------------------
// grs_back
// Holds the two-bank group buffer and drains each closed group newest first
// into a small result queue.
// ----------------------------------------------------------------------------
module grs_back #(
    parameter int MAX_GROUP = grs_pkg::GRS_MAX_GROUP
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  grs_pkg::t_grs_wr    i_wr,
    input  logic                i_q_empty,
    input  grs_pkg::t_grs_desc  i_head,
    output logic                o_q_pop,
    output logic [1:0]          o_release,
    output logic                empty,
    input  logic                pop,
    output grs_pkg::t_grs_out   o_result
);

    localparam int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int MEM_DEPTH = 2 << AW;
    localparam int OQ_AW     = $clog2(grs_pkg::GRS_OQ_DEPTH);
    localparam int OQ_CW     = OQ_AW + 1;

    // group buffer, one bank per half
    logic signed [grs_pkg::GRS_VAL_W-1:0] r_mem [MEM_DEPTH];

    grs_pkg::t_back_state r_state, n_state;
    logic                 r_bank;
    logic [AW-1:0]        r_addr;
    logic                 r_last;

    logic signed [grs_pkg::GRS_VAL_W-1:0] r_rd_data;
    logic                                 r_rd_valid;
    logic                                 r_rd_gend;
    logic                                 r_rd_lend;

    grs_pkg::t_grs_out  r_oq [grs_pkg::GRS_OQ_DEPTH];
    logic [OQ_AW-1:0]   r_oq_wp;
    logic [OQ_AW-1:0]   r_oq_rp;
    logic [OQ_CW-1:0]   r_oq_cnt;

    logic room;
    logic issue;
    logic at_tail;
    logic load;
    logic oq_pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            grs_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = grs_pkg::BK_DRAIN;
                end
            end
            grs_pkg::BK_DRAIN: begin
                if (issue && at_tail && i_q_empty) begin
                    n_state = grs_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = grs_pkg::BK_IDLE;
            end
        endcase
    end

    // drain control
    always_comb begin
        room    = (r_oq_cnt + OQ_CW'(r_rd_valid)) < OQ_CW'(grs_pkg::GRS_OQ_DEPTH);
        at_tail = (r_addr == '0);
        issue   = 1'b0;
        load    = 1'b0;
        case (r_state)
            grs_pkg::BK_IDLE: begin
                load = !i_q_empty;
            end
            grs_pkg::BK_DRAIN: begin
                issue = room;
                load  = room && at_tail && !i_q_empty;
            end
            default: begin
                issue = 1'b0;
                load  = 1'b0;
            end
        endcase
        o_q_pop   = load;
        o_release = (issue && at_tail) ? (2'b01 << r_bank) : 2'b00;
    end

    // state and drain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= grs_pkg::BK_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bank <= i_head.bank;
            r_addr <= i_head.top[AW-1:0];
            r_last <= i_head.last;
        end else if (issue) begin
            r_addr <= r_addr - AW'(1);
        end
    end

    // buffer write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.addr[AW-1:0]}] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[{r_bank, r_addr}];
            r_rd_gend <= at_tail;
            r_rd_lend <= at_tail && r_last;
        end
    end

    // result queue
    assign empty    = (r_oq_cnt == '0);
    assign oq_pop   = pop && !empty;
    assign o_result = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_rd_valid) begin
                r_oq_wp <= r_oq_wp + OQ_AW'(1);
            end
            if (oq_pop) begin
                r_oq_rp <= r_oq_rp + OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + OQ_CW'(r_rd_valid) - OQ_CW'(oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_oq[r_oq_wp] <= '{out_value: r_rd_data, group_end: r_rd_gend,
                               list_end: r_rd_lend};
        end
    end

    // result queue never holds more than its depth
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= OQ_CW'(grs_pkg::GRS_OQ_DEPTH))
        else $error("result queue overflow");

    // a bank is handed back only after its newest-to-oldest drain ends
    a_release_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_release != 2'b00) |-> (r_state == grs_pkg::BK_DRAIN && at_tail))
        else $error("bank released outside a drain");

endmodule

@@ rtl/core/group_reverse_stream_top.sv @@
// ----------------------------------------------------------------------------
// group_reverse_stream_top
// Reverses a stream of signed 32-bit values in groups of a set size.
//
// Input channel: push / full; an item is taken when push is high and full
// is low. Result channel: empty / pop; the oldest result sits on o_result
// while empty is low and leaves when pop is high.
// Configuration: i_cfg_we writes i_cfg_data into the group size; write it
// only while the block is idle. Size zero acts as one, sizes above
// MAX_GROUP act as MAX_GROUP.
// Each item goes into one of two buffer banks. A group closes when it fills
// or on an item marked list_last; its values come out newest first, the
// last of them flagged group_end and, for a list end, list_end.
// With the back end idle, a closed group's descriptor passes the descriptor
// queue, the back end loads it, and its newest value goes through the read
// register into the result queue. The front fills one bank while the back
// end drains the other, and holds off input while its current bank is still
// owed. Results leave at one per cycle while results are queued.
// Reset: group size 1, buffers and queues empty. When the receiver stalls,
// the 4-entry result queue fills, the drain stops, and full rises once both
// banks are owed.
// ----------------------------------------------------------------------------
module group_reverse_stream_top #(
    parameter int MAX_GROUP = grs_pkg::GRS_MAX_GROUP
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  grs_pkg::t_grs_in                i_item,
    output logic                            empty,
    input  logic                            pop,
    output grs_pkg::t_grs_out               o_result,
    input  logic                            i_cfg_we,
    input  logic [grs_pkg::GRS_SIZE_W-1:0]  i_cfg_data
);

    grs_pkg::t_grs_wr   wr;
    grs_pkg::t_grs_desc desc_in;
    grs_pkg::t_grs_desc desc_head;
    logic               desc_push;
    logic               desc_pop;
    logic               desc_empty;
    logic               desc_full;
    logic [1:0]         release_bank;

    // front: accept and group
    grs_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_release   (release_bank),
        .o_wr        (wr),
        .o_desc_push (desc_push),
        .o_desc      (desc_in)
    );

    // closed groups waiting for the back end
    grs_desc_queue u_desc_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_empty (desc_empty),
        .o_full  (desc_full),
        .o_head  (desc_head)
    );

    // back: reversed drain
    grs_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_q_empty (desc_empty),
        .i_head    (desc_head),
        .o_q_pop   (desc_pop),
        .o_release (release_bank),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

    // descriptor queue room is implied by the two bank busy flags
    a_desc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        desc_full |-> full)
        else $error("both groups owed but input not held off");

endmodule
